// ----- rtl/cppd_pkg.sv -----
// Shared types, codes and the microcode program of the pilot PWM decoder.
package cppd_pkg;

	localparam int STEP_W    = 5;
	localparam int CFG_IDX_W = 8;
	localparam int MUL_W     = 42;
	localparam int DIV_CNT_W = 5;
	localparam int DC_STEPS  = 25;
	localparam int QUO_W     = 25;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TIMER_CLOCK = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WALL_VOLT   = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EFFICIENCY  = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PACK_VOLT   = 8'd3;

	// multiplier operand A
	localparam logic [1:0] MA_P   = 2'd0;
	localparam logic [1:0] MA_H   = 2'd1;
	localparam logic [1:0] MA_AC  = 2'd2;
	localparam logic [1:0] MA_MUL = 2'd3;

	// multiplier operand B
	localparam logic [1:0] MB_CONST = 2'd0;
	localparam logic [1:0] MB_WALL  = 2'd1;
	localparam logic [1:0] MB_EFF   = 2'd2;

	// range checks
	localparam logic [2:0] CHK_NONE    = 3'd0;
	localparam logic [2:0] CHK_FREQ_LO = 3'd1;
	localparam logic [2:0] CHK_FREQ_HI = 3'd2;
	localparam logic [2:0] CHK_DUTY_LO = 3'd3;
	localparam logic [2:0] CHK_DUTY_HI = 3'd4;
	localparam logic [2:0] CHK_KNEE    = 3'd5;

	// t0 operations
	localparam logic [1:0] T0_NONE = 2'd0;
	localparam logic [1:0] T0_MUL  = 2'd1;
	localparam logic [1:0] T0_SUB  = 2'd2;

	// divider operations
	localparam logic [1:0] DIV_NONE     = 2'd0;
	localparam logic [1:0] DIV_START_AC = 2'd1;
	localparam logic [1:0] DIV_START_DC = 2'd2;
	localparam logic [1:0] DIV_STEP     = 2'd3;

	// result writes
	localparam logic [1:0] RES_NONE = 2'd0;
	localparam logic [1:0] RES_AC   = 2'd1;
	localparam logic [1:0] RES_DC   = 2'd2;

	// jump conditions
	localparam logic [2:0] JC_NEXT  = 3'd0;
	localparam logic [2:0] JC_GOTO  = 3'd1;
	localparam logic [2:0] JC_FAULT = 3'd2;
	localparam logic [2:0] JC_HI    = 3'd3;
	localparam logic [2:0] JC_DIV   = 3'd4;
	localparam logic [2:0] JC_IN    = 3'd5;
	localparam logic [2:0] JC_OUT   = 3'd6;

	// named program addresses
	localparam logic [STEP_W-1:0] ST_IDLE    = 5'd0;
	localparam logic [STEP_W-1:0] ST_HI_NUM  = 5'd10;
	localparam logic [STEP_W-1:0] ST_DIV_AC  = 5'd13;
	localparam logic [STEP_W-1:0] ST_AC_LOOP = 5'd14;
	localparam logic [STEP_W-1:0] ST_DC_LOOP = 5'd19;
	localparam logic [STEP_W-1:0] ST_FAULT   = 5'd21;
	localparam logic [STEP_W-1:0] ST_OUT     = 5'd22;

	typedef struct packed {
		logic              mul_en;
		logic [1:0]        mul_a;
		logic [1:0]        mul_b;
		logic [9:0]        k;
		logic [2:0]        chk;
		logic [1:0]        t0_op;
		logic              t1_ld;
		logic [1:0]        div_op;
		logic [1:0]        res_op;
		logic [2:0]        jc;
		logic [STEP_W-1:0] target;
	} uop_t;

	typedef struct packed {
		logic fault;
		logic hi;
		logic div_last;
	} flags_t;

	function automatic uop_t ucode(input logic [STEP_W-1:0] step);
		uop_t u;
		u = '0;
		case (step)
			5'd0: begin
				u.jc = JC_IN;
			end
			5'd1: begin
				u.mul_en = 1'b1; u.mul_a = MA_P; u.k = 10'd990;
			end
			5'd2: begin
				u.mul_en = 1'b1; u.mul_a = MA_P; u.k = 10'd1000;
				u.chk = CHK_FREQ_LO;
			end
			5'd3: begin
				u.mul_en = 1'b1; u.mul_a = MA_P; u.k = 10'd5;
				u.chk = CHK_FREQ_HI;
			end
			5'd4: begin
				u.mul_en = 1'b1; u.mul_a = MA_H; u.k = 10'd100;
				u.t0_op = T0_MUL;
			end
			5'd5: begin
				u.mul_en = 1'b1; u.mul_a = MA_P; u.k = 10'd95;
				u.t1_ld = 1'b1; u.chk = CHK_DUTY_LO;
			end
			5'd6: begin
				u.mul_en = 1'b1; u.mul_a = MA_P; u.k = 10'd85;
				u.chk = CHK_DUTY_HI;
			end
			5'd7: begin
				u.chk = CHK_KNEE; u.jc = JC_FAULT; u.target = ST_FAULT;
			end
			5'd8: begin
				u.mul_en = 1'b1; u.mul_a = MA_H; u.k = 10'd60;
				u.jc = JC_HI; u.target = ST_HI_NUM;
			end
			5'd9: begin
				u.t0_op = T0_MUL; u.jc = JC_GOTO; u.target = ST_DIV_AC;
			end
			5'd10: begin
				u.mul_en = 1'b1; u.mul_a = MA_H; u.k = 10'd250;
			end
			5'd11: begin
				u.mul_en = 1'b1; u.mul_a = MA_P; u.k = 10'd160;
				u.t0_op = T0_MUL;
			end
			5'd12: begin
				u.t0_op = T0_SUB;
			end
			5'd13: begin
				u.div_op = DIV_START_AC;
			end
			5'd14: begin
				u.div_op = DIV_STEP; u.jc = JC_DIV; u.target = ST_AC_LOOP;
			end
			5'd15: begin
				u.res_op = RES_AC;
			end
			5'd16: begin
				u.mul_en = 1'b1; u.mul_a = MA_AC; u.mul_b = MB_WALL;
			end
			5'd17: begin
				u.mul_en = 1'b1; u.mul_a = MA_MUL; u.mul_b = MB_EFF;
			end
			5'd18: begin
				u.div_op = DIV_START_DC;
			end
			5'd19: begin
				u.div_op = DIV_STEP; u.jc = JC_DIV; u.target = ST_DC_LOOP;
			end
			5'd20: begin
				u.res_op = RES_DC; u.jc = JC_GOTO; u.target = ST_OUT;
			end
			5'd21: begin
				u.jc = JC_NEXT;
			end
			5'd22: begin
				u.jc = JC_OUT; u.target = ST_IDLE;
			end
			default: begin
				u.jc = JC_GOTO; u.target = ST_IDLE;
			end
		endcase
		return u;
	endfunction

endpackage

// ----- rtl/charge_pilot_pwm_decoder_top.sv -----
// Pilot PWM decoder: stream ports, configuration registers and output register.
// The restoring divider (one quotient bit per cycle) runs twice per valid capture, once for the AC
// and once for the DC quotient; a fault skips it, and the output register may wait on m_tready.
// A new capture is accepted only once the result of the last one has loaded into the output
// register, so the block never holds more than one capture in flight.
// Reset clears the held currents and loads the default register values.
module charge_pilot_pwm_decoder_top #(
	parameter int AMP_FRACTION_BITS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [63:0]                       s_tdata,   // period_count, high_count
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [31:0]                       m_tdata,   // ac_amps_q8, dc_amps_q8, zero pad
	output logic                              m_tuser,   // pilot_status
	input  logic                              cfg_we,
	input  logic [cppd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [31:0]                       cfg_data
);

	logic [31:0]      timer_clock_q;
	logic [8:0]       wall_voltage_q;
	logic [8:0]       efficiency_q;
	logic [9:0]       pack_voltage_q;
	cppd_pkg::uop_t   uop;
	cppd_pkg::flags_t flags;
	logic             in_fire;
	logic             out_free;
	logic             out_load;
	logic             status;
	logic [14:0]      ac_amps;
	logic [15:0]      dc_amps;
	logic             out_valid_q;
	logic             out_status_q;
	logic [14:0]      out_ac_q;
	logic [15:0]      out_dc_q;

	assign s_tready = uop.jc == cppd_pkg::JC_IN;
	assign in_fire  = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign out_load = (uop.jc == cppd_pkg::JC_OUT) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_clock_q  <= 32'd1000000;
			wall_voltage_q <= 9'd240;
			efficiency_q   <= 9'd230;
			pack_voltage_q <= 10'd400;
		end else if (cfg_we) begin
			case (cfg_index)
				cppd_pkg::REG_TIMER_CLOCK: timer_clock_q  <= cfg_data;
				cppd_pkg::REG_WALL_VOLT:   wall_voltage_q <= cfg_data[8:0];
				cppd_pkg::REG_EFFICIENCY:  efficiency_q   <= cfg_data[8:0];
				cppd_pkg::REG_PACK_VOLT:   pack_voltage_q <= cfg_data[9:0];
				default:                   timer_clock_q  <= timer_clock_q;
			endcase
		end
	end

	cppd_sequencer u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_fire (in_fire),
		.out_free(out_free),
		.flags   (flags),
		.uop     (uop)
	);

	cppd_datapath #(
		.AMP_FRACTION_BITS(AMP_FRACTION_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.uop           (uop),
		.in_fire       (in_fire),
		.period_count  (s_tdata[31:0]),
		.high_count    (s_tdata[63:32]),
		.timer_clock_hz(timer_clock_q),
		.wall_voltage  (wall_voltage_q),
		.efficiency_q8 (efficiency_q),
		.pack_voltage  (pack_voltage_q),
		.flags         (flags),
		.pilot_status  (status),
		.ac_amps_q8    (ac_amps),
		.dc_amps_q8    (dc_amps)
	);

	// hold the result until the downstream side takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= status;
			out_ac_q     <= ac_amps;
			out_dc_q     <= dc_amps;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_dc_q, out_ac_q};
	assign m_tuser  = out_status_q;

endmodule

// ----- rtl/cppd_sequencer.sv -----
// Step counter and control word fetch with conditional jumps.
module cppd_sequencer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_fire,
	input  logic                out_free,
	input  cppd_pkg::flags_t    flags,
	output cppd_pkg::uop_t      uop
);

	logic [cppd_pkg::STEP_W-1:0] step_q;
	logic [cppd_pkg::STEP_W-1:0] step_next;
	logic [cppd_pkg::STEP_W-1:0] step_inc;

	assign uop      = cppd_pkg::ucode(step_q);
	assign step_inc = step_q + cppd_pkg::STEP_W'(1);

	always_comb begin
		case (uop.jc)
			cppd_pkg::JC_NEXT:  step_next = step_inc;
			cppd_pkg::JC_GOTO:  step_next = uop.target;
			cppd_pkg::JC_FAULT: step_next = flags.fault ? uop.target : step_inc;
			cppd_pkg::JC_HI:    step_next = flags.hi ? uop.target : step_inc;
			cppd_pkg::JC_DIV:   step_next = flags.div_last ? step_inc : uop.target;
			cppd_pkg::JC_IN:    step_next = in_fire ? step_inc : step_q;
			cppd_pkg::JC_OUT:   step_next = out_free ? uop.target : step_q;
			default:            step_next = cppd_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= cppd_pkg::ST_IDLE;
		end else begin
			step_q <= step_next;
		end
	end

endmodule

// ----- rtl/cppd_divider.sv -----
// Restoring divider, one quotient bit per cycle, shared by the AC and DC quotients.
module cppd_divider #(
	parameter int AMP_FRACTION_BITS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [1:0]                    op,
	input  logic [39:0]                   num_ac,
	input  logic [cppd_pkg::QUO_W-1:0]    num_dc,
	input  logic [31:0]                   period,
	input  logic [9:0]                    pack_div,
	output logic [cppd_pkg::QUO_W-1:0]    quo,
	output logic                          last
);

	localparam int RW       = 40 + AMP_FRACTION_BITS;
	localparam int AC_STEPS = AMP_FRACTION_BITS + 7;

	logic [RW-1:0]                      rem_q;
	logic [RW-1:0]                      dv_q;
	logic [cppd_pkg::QUO_W-1:0]         quo_q;
	logic [cppd_pkg::DIV_CNT_W-1:0]     cnt_q;
	logic                               fits;

	assign fits = rem_q >= dv_q;
	assign quo  = quo_q;
	assign last = cnt_q == cppd_pkg::DIV_CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case (op)
				cppd_pkg::DIV_START_AC: cnt_q <= cppd_pkg::DIV_CNT_W'(AC_STEPS);
				cppd_pkg::DIV_START_DC: cnt_q <= cppd_pkg::DIV_CNT_W'(cppd_pkg::DC_STEPS);
				cppd_pkg::DIV_STEP:     cnt_q <= cnt_q - cppd_pkg::DIV_CNT_W'(1);
				default:                cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			cppd_pkg::DIV_START_AC: begin
				rem_q <= RW'(num_ac) << AMP_FRACTION_BITS;
				dv_q  <= RW'(period) << (AC_STEPS - 1);
				quo_q <= '0;
			end
			cppd_pkg::DIV_START_DC: begin
				rem_q <= RW'(num_dc);
				dv_q  <= RW'(pack_div) << (cppd_pkg::DC_STEPS - 1);
				quo_q <= '0;
			end
			cppd_pkg::DIV_STEP: begin
				if (fits) begin
					rem_q <= rem_q - dv_q;
				end
				quo_q <= {quo_q[cppd_pkg::QUO_W-2:0], fits};
				dv_q  <= dv_q >> 1;
			end
			default: begin
				rem_q <= rem_q;
			end
		endcase
	end

endmodule

// ----- rtl/cppd_datapath.sv -----
// Shared multiplier, compare flags, scratch registers and held currents.
module cppd_datapath #(
	parameter int AMP_FRACTION_BITS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cppd_pkg::uop_t      uop,
	input  logic                in_fire,
	input  logic [31:0]         period_count,
	input  logic [31:0]         high_count,
	input  logic [31:0]         timer_clock_hz,
	input  logic [8:0]          wall_voltage,
	input  logic [8:0]          efficiency_q8,
	input  logic [9:0]          pack_voltage,
	output cppd_pkg::flags_t    flags,
	output logic                pilot_status,
	output logic [14:0]         ac_amps_q8,
	output logic [15:0]         dc_amps_q8
);

	localparam int MW = cppd_pkg::MUL_W;

	logic [31:0]                    p_q;
	logic [31:0]                    h_q;
	logic [MW-1:0]                  mul_q;
	logic [MW-1:0]                  t0_q;
	logic [MW-1:0]                  t1_q;
	logic                           fault_q;
	logic                           hi_q;
	logic                           status_q;
	logic [14:0]                    ac_q;
	logic [15:0]                    dc_q;
	logic [31:0]                    op_a;
	logic [9:0]                     op_b;
	logic [MW-1:0]                  clk_ext;
	logic                           chk_fail;
	logic [9:0]                     pack_div;
	logic [cppd_pkg::QUO_W-1:0]     quo;
	logic                           div_last;

	assign clk_ext  = MW'(timer_clock_hz);
	assign pack_div = (pack_voltage == 10'd0) ? 10'd1 : pack_voltage;

	always_comb begin
		case (uop.mul_a)
			cppd_pkg::MA_P:   op_a = p_q;
			cppd_pkg::MA_H:   op_a = h_q;
			cppd_pkg::MA_AC:  op_a = 32'(ac_q);
			cppd_pkg::MA_MUL: op_a = mul_q[31:0];
			default:          op_a = p_q;
		endcase
		case (uop.mul_b)
			cppd_pkg::MB_CONST: op_b = uop.k;
			cppd_pkg::MB_WALL:  op_b = 10'(wall_voltage);
			cppd_pkg::MB_EFF:   op_b = 10'(efficiency_q8);
			default:            op_b = uop.k;
		endcase
	end

	always_comb begin
		case (uop.chk)
			cppd_pkg::CHK_FREQ_LO: chk_fail = (p_q == 32'd0) || (mul_q > clk_ext);
			cppd_pkg::CHK_FREQ_HI: chk_fail = clk_ext > mul_q;
			cppd_pkg::CHK_DUTY_LO: chk_fail = mul_q < t0_q;
			cppd_pkg::CHK_DUTY_HI: chk_fail = t1_q > mul_q;
			default:               chk_fail = 1'b0;
		endcase
	end

	// operands and scratch values
	always_ff @(posedge clk) begin
		if (in_fire) begin
			p_q <= period_count;
			h_q <= high_count;
		end
		if (uop.mul_en) begin
			mul_q <= MW'(op_a) * MW'(op_b);
		end
		case (uop.t0_op)
			cppd_pkg::T0_MUL: t0_q <= mul_q;
			cppd_pkg::T0_SUB: t0_q <= t0_q - mul_q;
			default:          t0_q <= t0_q;
		endcase
		if (uop.t1_ld) begin
			t1_q <= mul_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fault_q  <= 1'b0;
			hi_q     <= 1'b0;
			status_q <= 1'b0;
			ac_q     <= '0;
			dc_q     <= '0;
		end else begin
			if (in_fire) begin
				fault_q  <= 1'b0;
				hi_q     <= 1'b0;
			end else begin
				if (chk_fail) begin
					fault_q <= 1'b1;
				end
				if (uop.chk == cppd_pkg::CHK_KNEE) begin
					hi_q <= t1_q > mul_q;
				end
			end
			case (uop.res_op)
				cppd_pkg::RES_AC: begin
					ac_q <= (quo > cppd_pkg::QUO_W'(32767)) ? 15'h7fff : quo[14:0];
				end
				cppd_pkg::RES_DC: begin
					dc_q     <= (quo > cppd_pkg::QUO_W'(65535)) ? 16'hffff : quo[15:0];
					status_q <= 1'b1;
				end
				default: begin
					status_q <= status_q & ~in_fire;
				end
			endcase
		end
	end

	cppd_divider #(
		.AMP_FRACTION_BITS(AMP_FRACTION_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.op      (uop.div_op),
		.num_ac  (t0_q[39:0]),
		.num_dc  (mul_q[32:8]),
		.period  (p_q),
		.pack_div(pack_div),
		.quo     (quo),
		.last    (div_last)
	);

	assign flags.fault    = fault_q;
	assign flags.hi       = hi_q;
	assign flags.div_last = div_last;

	assign pilot_status = status_q;
	assign ac_amps_q8   = ac_q;
	assign dc_amps_q8   = dc_q;

endmodule

// ----- bench/tb_charge_pilot_pwm_decoder_top.sv -----
// Testbench of the pilot PWM decoder: directed and random captures checked against a local decoder.
module tb_charge_pilot_pwm_decoder_top;

	localparam int AMP_FRACTION_BITS = 8;
	localparam int HALF_PERIOD = 6;
	localparam int RESET_CYCLES = 9;
	localparam int SETTLE_CYCLES = 64;
	localparam int STALL_LIMIT = 5000;
	localparam logic [cppd_pkg::CFG_IDX_W-1:0] REG_UNUSED_LO = 8'd4;
	localparam logic [cppd_pkg::CFG_IDX_W-1:0] REG_UNUSED_HI = 8'd255;
	localparam logic [14:0] AC_SAT = 15'h7fff;
	localparam logic [15:0] DC_SAT = 16'hffff;

	typedef struct {
		bit        pilot_ok;
		bit [14:0] ac_amps;
		bit [15:0] dc_amps;
	} pilot_reading_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [63:0]                    s_tdata = '0;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [31:0]                    m_tdata;
	logic                           m_tuser;
	logic                           cfg_we = 1'b0;
	logic [cppd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]                    cfg_data = '0;

	// local copy of the registers and the held currents
	bit [31:0] cfg_timer_clk = 32'd1000000;
	bit [8:0]  cfg_wall = 9'd240;
	bit [8:0]  cfg_eff = 9'd230;
	bit [9:0]  cfg_pack = 10'd400;
	bit [14:0] held_ac = '0;
	bit [15:0] held_dc = '0;

	pilot_reading_t expected_readings[$];
	int failures = 0;
	int captures_sent = 0;
	int valid_pilots = 0;
	int cfg_writes = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;

	charge_pilot_pwm_decoder_top #(
		.AMP_FRACTION_BITS(AMP_FRACTION_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	function automatic pilot_reading_t decode_pilot(bit [31:0] period, bit [31:0] high);
		bit [63:0] p;
		bit [63:0] h;
		bit [63:0] rate;
		bit [63:0] num;
		bit [63:0] q;
		bit [63:0] pv;
		pilot_reading_t r;
		p = period;
		h = high;
		rate = cfg_timer_clk;
		r.pilot_ok = 1'b0;
		if (p != 0 && p * 990 <= rate && rate <= p * 1000 &&
				h * 100 >= p * 5 && h * 100 <= p * 95) begin
			// below the knee amps = duty * 0.6, above it (duty - 64) * 2.5
			if (h * 100 <= p * 85)
				num = h * 60;
			else
				num = h * 250 - p * 160;
			q = (num << AMP_FRACTION_BITS) / p;
			held_ac = (q > AC_SAT) ? AC_SAT : q[14:0];
			pv = (cfg_pack == 0) ? 64'd1 : 64'(cfg_pack);
			q = 64'(held_ac) * cfg_wall * cfg_eff / (pv * 256);
			held_dc = (q > DC_SAT) ? DC_SAT : q[15:0];
			r.pilot_ok = 1'b1;
		end
		r.ac_amps = held_ac;
		r.dc_amps = held_dc;
		return r;
	endfunction

	// receiver: stall at random, decided at the falling edge
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		pilot_reading_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_readings.size() == 0) begin
				$error("result with no capture waiting: tuser=%0d tdata=%h", m_tuser, m_tdata);
				failures++;
			end else begin
				want = expected_readings.pop_front();
				if (m_tuser !== want.pilot_ok) begin
					$error("pilot_status: expected %0d, got %0d", want.pilot_ok, m_tuser);
					failures++;
				end
				if (m_tdata[14:0] !== want.ac_amps) begin
					$error("ac_amps_q8: expected %0d, got %0d", want.ac_amps, m_tdata[14:0]);
					failures++;
				end
				if (m_tdata[30:15] !== want.dc_amps) begin
					$error("dc_amps_q8: expected %0d, got %0d", want.dc_amps, m_tdata[30:15]);
					failures++;
				end
			end
		end
	end

	// watchdog: any transaction or register write counts as progress
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			quiet_cycles <= 0;
		else if (quiet_cycles >= STALL_LIMIT) begin
			$display("charge_pilot_pwm_decoder_top test failed");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	// entered and left at a falling edge; tvalid stays high on return
	task automatic send_capture(bit [31:0] period, bit [31:0] high);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {high, period};
		do
			@(posedge clk);
		while (!s_tready);
		expected_readings.push_back(decode_pilot(period, high));
		captures_sent++;
		if (expected_readings[$].pilot_ok)
			valid_pilots++;
		@(negedge clk);
	endtask

	task automatic settle_outputs();
		s_tvalid <= 1'b0;
		while (expected_readings.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [cppd_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			cppd_pkg::REG_TIMER_CLOCK: cfg_timer_clk = value;
			cppd_pkg::REG_WALL_VOLT:   cfg_wall = value[8:0];
			cppd_pkg::REG_EFFICIENCY:  cfg_eff = value[8:0];
			cppd_pkg::REG_PACK_VOLT:   cfg_pack = value[9:0];
			default: ;
		endcase
		cfg_writes++;
		@(negedge clk);
	endtask

	task automatic write_all_regs(bit [31:0] rate, bit [8:0] wall, bit [8:0] eff, bit [9:0] pack);
		write_reg(cppd_pkg::REG_TIMER_CLOCK, rate);
		write_reg(cppd_pkg::REG_WALL_VOLT, 32'(wall));
		write_reg(cppd_pkg::REG_EFFICIENCY, 32'(eff));
		write_reg(cppd_pkg::REG_PACK_VOLT, 32'(pack));
	endtask

	// mostly captures near the valid window of the current timer clock, some noise
	task automatic pick_capture(output bit [31:0] period, output bit [31:0] high);
		bit [63:0] p_lo;
		bit [63:0] p_hi;
		bit [63:0] h_lo;
		bit [63:0] h_hi;
		bit [63:0] knee;
		int sel;
		p_lo = (64'(cfg_timer_clk) + 999) / 1000;
		p_hi = 64'(cfg_timer_clk) / 990;
		if (p_lo == 0)
			p_lo = 1;
		sel = $urandom_range(99);
		if (p_lo > p_hi || sel < 12) begin
			period = $urandom;
			high = sel[0] ? $urandom : $urandom_range(period, 0);
			return;
		end
		sel = $urandom_range(99);
		if (sel < 6)
			period = 32'(p_lo - 1);
		else if (sel < 12)
			period = 32'(p_hi + 1);
		else if (sel < 20)
			period = sel[0] ? 32'(p_lo) : 32'(p_hi);
		else
			period = $urandom_range(32'(p_hi), 32'(p_lo));
		h_lo = (64'(period) * 5 + 99) / 100;
		h_hi = 64'(period) * 95 / 100;
		knee = 64'(period) * 85 / 100;
		case ($urandom_range(11))
			0: high = 32'(h_lo - 1);
			1: high = 32'(h_lo);
			2: high = 32'(knee);
			3: high = 32'(knee + 1);
			4: high = 32'(h_hi);
			5: high = 32'(h_hi + 1);
			default: high = $urandom_range(32'(h_hi), 32'(h_lo));
		endcase
	endtask

	// pause_every > 0: hold the sender until every result is back that often
	task automatic run_random_captures(int count, int pause_every);
		bit [31:0] period;
		bit [31:0] high;
		for (int i = 0; i < count; i++) begin
			pick_capture(period, high);
			send_capture(period, high);
			if (pause_every > 0 && i % pause_every == pause_every - 1) begin
				s_tvalid <= 1'b0;
				while (expected_readings.size() != 0)
					@(negedge clk);
			end
		end
	endtask

	task automatic test_directed_decode();
		send_capture(32'd0, 32'd0);
		send_capture(32'd1000, 32'd500);
		send_capture(32'd0, 32'hffffffff);
		send_capture(32'hffffffff, 32'hffffffff);
		send_capture(32'd1000, 32'd50);
		send_capture(32'd1000, 32'd49);
		send_capture(32'd1000, 32'd950);
		send_capture(32'd1000, 32'd951);
		send_capture(32'd1000, 32'd850);
		send_capture(32'd1000, 32'd851);
		send_capture(32'd1010, 32'd505);
		send_capture(32'd1011, 32'd505);
		send_capture(32'd999, 32'd500);
		send_capture(32'd1000, 32'd0);
		send_capture(32'd1005, 32'd1005);
		send_capture(32'd1003, 32'd777);
		send_capture(32'hffffffff, 32'd0);
		settle_outputs();
	endtask

	task automatic test_gain_extremes();
		send_idle_pct = 22;
		recv_stall_pct = 22;
		// saturate the DC estimate: top timer clock, top gains, pack of one volt
		write_all_regs(32'hffffffff, 9'd511, 9'd511, 10'd1);
		send_capture(32'd4294968, 32'd4080219);
		send_capture(32'd4338350, 32'd216918);
		send_capture(32'd4338351, 32'd216918);
		send_capture(32'd4294967, 32'd2000000);
		run_random_captures(56, 0);
		settle_outputs();
		// zero pack voltage is taken as one volt
		write_reg(cppd_pkg::REG_EFFICIENCY, 32'd256);
		write_reg(cppd_pkg::REG_PACK_VOLT, 32'd0);
		run_random_captures(40, 0);
		settle_outputs();
		write_reg(cppd_pkg::REG_WALL_VOLT, 32'd0);
		write_reg(cppd_pkg::REG_EFFICIENCY, 32'd0);
		write_reg(cppd_pkg::REG_PACK_VOLT, 32'd1023);
		run_random_captures(40, 0);
		settle_outputs();
	endtask

	task automatic test_timer_clock_edges();
		// a zero or one hertz timer clock leaves no valid period
		write_reg(cppd_pkg::REG_TIMER_CLOCK, 32'd0);
		send_capture(32'd1, 32'd1);
		run_random_captures(19, 0);
		settle_outputs();
		write_reg(cppd_pkg::REG_TIMER_CLOCK, 32'd1);
		send_capture(32'd1, 32'd1);
		run_random_captures(19, 0);
		settle_outputs();
	endtask

	task automatic test_unused_index();
		write_all_regs(32'd1000000, 9'd240, 9'd230, 10'd400);
		write_reg(REG_UNUSED_LO, 32'hffffffff);
		write_reg(REG_UNUSED_HI, 32'h00000000);
		run_random_captures(30, 0);
		settle_outputs();
	endtask

	task automatic test_random_traffic();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		write_all_regs(32'd1000000, 9'd240, 9'd230, 10'd400);
		run_random_captures(380, 0);
		settle_outputs();

		send_idle_pct = 72;
		recv_stall_pct = 0;
		write_all_regs(32'd100000, 9'd120, 9'd256, 10'd1023);
		run_random_captures(380, 50);
		settle_outputs();

		send_idle_pct = 0;
		recv_stall_pct = 72;
		write_all_regs($urandom_range(32'hffffffff, 32'd20000), 9'($urandom_range(511)),
			9'($urandom_range(256)), 10'($urandom_range(1023, 1)));
		run_random_captures(380, 0);
		settle_outputs();

		send_idle_pct = 22;
		recv_stall_pct = 22;
		write_all_regs(32'd1000000, 9'd511, 9'd256, 10'd50);
		run_random_captures(380, 0);
		settle_outputs();
	endtask

	initial begin
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed_decode();
		test_gain_extremes();
		test_timer_clock_edges();
		test_unused_index();
		test_random_traffic();
		$display("Sent %0d captures (%0d valid pilots) over %0d register writes,",
			captures_sent, valid_pilots, cfg_writes);
		$display("with idle and stall mixes of 0, 22 and 72 percent on each side.");
		if (failures == 0 && expected_readings.size() == 0)
			$display("charge_pilot_pwm_decoder_top test passed");
		else
			$display("charge_pilot_pwm_decoder_top test failed");
		$finish;
	end

endmodule
